// File: hw/rtl/ity_pkg.sv
// shared types, character codes and helper functions for the infix-to-postfix converter
package ity_pkg;

  localparam int CHAR_W = 8;

  // character codes
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

  // command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // error codes carried on the terminator
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_t;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_OPER,
    ST_FLUSH
  } state_t;

  // shift command broadcast to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

  // operator priority, lower binds tighter
  function automatic logic [2:0] prio(input logic [CHAR_W-1:0] c);
    logic [2:0] p;
    case (c)
      CH_CARET: p = 3'd2;
      CH_STAR, CH_SLASH: p = 3'd3;
      CH_PLUS, CH_MINUS: p = 3'd4;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  // letters and digits pass straight through
  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]};
  endfunction

endpackage

// File: hw/rtl/ity_cell.sv
// one stack cell: holds an entry and shifts with its neighbors on push and pop
module ity_cell (
  input  logic                          clk,
  input  ity_pkg::stk_op_t              ctl,
  input  logic [ity_pkg::CHAR_W-1:0]    above,
  input  logic [ity_pkg::CHAR_W-1:0]    below,
  output logic [ity_pkg::CHAR_W-1:0]    q
);

  // push takes the entry from above, pop takes the entry from below
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= above;
    end else if (ctl.pop) begin
      q <= below;
    end
  end

endmodule

// File: hw/rtl/infix_to_postfix_converter.sv
// top level: shunting-yard infix-to-postfix converter over a row of stack cells
// a letter or digit is written into the output register when its request is taken
// letters, digits and '(' are handled in the idle state; an operator or ')' pops and emits entries
// in its own state and an end request flushes every stacked entry, the input stalling until idle
// one pop a cycle while the output is not stalled, set by the shift of the cell row, which moves one entry per cycle
// reset (rst, synchronous) empties the stack, clears the error code and the output valid
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [ity_pkg::CHAR_W-1:0]    in_char,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ity_pkg::CHAR_W-1:0]    out_char,
  output logic                          is_end,
  output logic [1:0]                    err
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  ity_pkg::state_t                state, state_next;
  logic [CNT_W-1:0]               count;
  ity_pkg::err_t                  error_code, err_next;
  logic [ity_pkg::CHAR_W-1:0]     opr;
  ity_pkg::stk_op_t               stk;
  logic [ity_pkg::CHAR_W-1:0]     push_char;
  logic [ity_pkg::CHAR_W-1:0]     cells [STACK_DEPTH];
  logic [ity_pkg::CHAR_W-1:0]     top;
  logic                           out_free, in_accept, empty, full;
  logic                           emit, emit_end;
  logic [ity_pkg::CHAR_W-1:0]     emit_char;
  ity_pkg::err_t                  emit_err;

  assign top       = cells[0];
  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(STACK_DEPTH));
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == ity_pkg::ST_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  // row of stack cells, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ity_pkg::CHAR_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = push_char;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_low
      assign below = cells[i+1];
    end
    ity_cell u_cell (
      .clk   (clk),
      .ctl   (stk),
      .above (above),
      .below (below),
      .q     (cells[i])
    );
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ity_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, stack command and emitted item
  always_comb begin
    state_next = state;
    stk        = '{push: 1'b0, pop: 1'b0};
    push_char  = in_char;
    emit       = 1'b0;
    emit_char  = top;
    emit_end   = 1'b0;
    emit_err   = ity_pkg::ERR_NONE;
    err_next   = error_code;
    case (state)
      ity_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (cmd == ity_pkg::CMD_END) begin
            state_next = ity_pkg::ST_FLUSH;
          end else if (ity_pkg::is_alnum(in_char)) begin
            emit      = 1'b1;
            emit_char = in_char;
          end else if (in_char == ity_pkg::CH_LPAREN) begin
            if (full) begin
              if (error_code == ity_pkg::ERR_NONE) err_next = ity_pkg::ERR_OVERFLOW;
            end else begin
              stk.push = 1'b1;
            end
          end else if (in_char == ity_pkg::CH_RPAREN) begin
            state_next = ity_pkg::ST_CLOSE;
          end else begin
            state_next = ity_pkg::ST_OPER;
          end
        end
      end
      ity_pkg::ST_CLOSE: begin
        if (empty) begin
          if (error_code == ity_pkg::ERR_NONE) err_next = ity_pkg::ERR_UNMATCHED;
          state_next = ity_pkg::ST_IDLE;
        end else if (top == ity_pkg::CH_LPAREN) begin
          stk.pop    = 1'b1;
          state_next = ity_pkg::ST_IDLE;
        end else if (out_free) begin
          emit    = 1'b1;
          stk.pop = 1'b1;
        end
      end
      ity_pkg::ST_OPER: begin
        push_char = opr;
        if (!empty && top != ity_pkg::CH_LPAREN &&
            ity_pkg::prio(top) <= ity_pkg::prio(opr)) begin
          if (out_free) begin
            emit    = 1'b1;
            stk.pop = 1'b1;
          end
        end else begin
          if (full) begin
            if (error_code == ity_pkg::ERR_NONE) err_next = ity_pkg::ERR_OVERFLOW;
          end else begin
            stk.push = 1'b1;
          end
          state_next = ity_pkg::ST_IDLE;
        end
      end
      ity_pkg::ST_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (!empty) begin
            stk.pop = 1'b1;
          end else begin
            emit_char  = ity_pkg::CH_NUL;
            emit_end   = 1'b1;
            emit_err   = error_code;
            err_next   = ity_pkg::ERR_NONE;
            state_next = ity_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ity_pkg::ST_IDLE;
      end
    endcase
  end

  // stack count and first error of the expression
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      error_code <= ity_pkg::ERR_NONE;
    end else begin
      error_code <= err_next;
      if (stk.push) begin
        count <= count + 1'b1;
      end else if (stk.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // operator held while the stack is popped
  always_ff @(posedge clk) begin
    if (in_accept) begin
      opr <= in_char;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_char <= emit_char;
      is_end   <= emit_end;
      err      <= emit_err;
    end
  end

endmodule

// File: hw/rtl/ity_checker.sv
// port-level checks for the infix-to-postfix converter, bound to the top level
module ity_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       cmd,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ity_pkg::CHAR_W-1:0] out_char,
  input logic                       is_end,
  input logic [1:0]                 err
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(is_end) && $stable(err))
    else $error("stalled result changed");

  // terminator carries a null character
  a_end_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_end |-> out_char == ity_pkg::CH_NUL)
    else $error("terminator with nonzero character");

  // only the terminator carries an error code
  a_err_only_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_end |-> err == ity_pkg::ERR_NONE)
    else $error("error code on a character result");

  // error code is one of the defined codes
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> err != 2'd3)
    else $error("undefined error code");

  // once an end request is taken, the input is seen stalled as the flush begins
  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == ity_pkg::CMD_END |=> in_stall)
    else $error("new request taken during flush");

endmodule

bind infix_to_postfix_converter ity_checker u_ity_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .is_end    (is_end),
  .err       (err)
);
